// ===== rtl/utf8d_pkg.sv =====
`default_nettype none

package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned MaxW   = 16;
  localparam int unsigned CmpW   = 32;
  localparam int unsigned CountW = 16;

  localparam logic [ByteW-1:0] Lead2Mask = 8'h1F;
  localparam logic [ByteW-1:0] Lead3Mask = 8'h0F;
  localparam logic [ByteW-1:0] Lead4Mask = 8'h07;
  localparam logic [ByteW-1:0] ContMask  = 8'h3F;
  localparam logic [ByteW-1:0] AsciiLim  = 8'h80;
  localparam logic [ByteW-1:0] Lead2Min  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Min  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Min  = 8'hF0;
  localparam logic [ByteW-1:0] BadMin    = 8'hF8;

  typedef enum logic [1:0] {
    ST_CHAR  = 2'd0,
    ST_LIMIT = 2'd1,
    ST_NUL   = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef struct packed {
    logic           finished;
    logic [1:0]     pending;
    logic [CpW-1:0] partial;
  } dec_state_t;

  typedef struct packed {
    logic           valid;
    logic [CpW-1:0] code_point;
    status_e        status;
  } dec_res_t;

endpackage

`default_nettype wire

// ===== rtl/utf8d_if.sv =====
`default_nettype none

interface utf8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_string;

  modport source (output valid, output data_byte, output start_string, input ready);
  modport sink (input valid, input data_byte, input start_string, output ready);
endinterface

interface utf8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [1:0]  status;
  logic [15:0] char_count;

  modport source (output valid, output code_point, output status, output char_count,
                  input ready);
  modport sink (input valid, input code_point, input status, input char_count,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/utf8d_step.sv =====
`default_nettype none

module utf8d_step #(
  parameter longint unsigned COUNT_MAX = 65535,
  parameter int unsigned     CNT_W     = 16
) (
  input  logic [7:0]              data_byte_i,
  input  logic                    start_string_i,
  input  utf8d_pkg::dec_state_t   state_i,
  input  logic [CNT_W-1:0]        count_i,
  input  logic [15:0]             max_chars_i,
  output utf8d_pkg::dec_state_t   state_o,
  output logic [CNT_W-1:0]        count_o,
  output utf8d_pkg::dec_res_t     res_o
);
  import utf8d_pkg::*;

  dec_state_t       st;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_inc;
  logic [CpW-1:0]   shifted;
  logic [1:0]       pend_dec;
  logic             lim_now;
  logic             lim_inc;

  always_comb begin
    st  = start_string_i ? '0 : state_i;
    cnt = start_string_i ? '0 : count_i;
    cnt_inc  = (cnt == CNT_W'(COUNT_MAX)) ? cnt : cnt + CNT_W'(1);
    lim_now  = CmpW'(cnt) >= CmpW'(max_chars_i);
    lim_inc  = CmpW'(cnt_inc) >= CmpW'(max_chars_i);
    shifted  = {st.partial[CpW-7:0], data_byte_i[5:0] & ContMask[5:0]};
    pend_dec = st.pending - 2'd1;
  end

  always_comb begin
    state_o = st;
    count_o = cnt;
    res_o   = '{valid: 1'b0, code_point: '0, status: ST_CHAR};
    if (!st.finished) begin
      if (st.pending != 2'd0) begin
        state_o.partial = shifted;
        state_o.pending = pend_dec;
        if (pend_dec == 2'd0) begin
          count_o           = cnt_inc;
          res_o.valid       = 1'b1;
          res_o.code_point  = shifted;
          res_o.status      = lim_inc ? ST_LIMIT : ST_CHAR;
          state_o.finished  = lim_inc;
        end
      end else if (lim_now) begin
        state_o.finished = 1'b1;
        res_o.valid      = 1'b1;
        res_o.status     = ST_LIMIT;
      end else if (data_byte_i == '0) begin
        state_o.finished = 1'b1;
        res_o.valid      = 1'b1;
        res_o.status     = ST_NUL;
      end else if (data_byte_i < AsciiLim) begin
        count_o          = cnt_inc;
        res_o.valid      = 1'b1;
        res_o.code_point = CpW'(data_byte_i);
        res_o.status     = lim_inc ? ST_LIMIT : ST_CHAR;
        state_o.finished = lim_inc;
      end else if (data_byte_i < Lead2Min || data_byte_i >= BadMin) begin
        state_o.finished = 1'b1;
        res_o.valid      = 1'b1;
        res_o.status     = ST_BAD;
      end else if (data_byte_i < Lead3Min) begin
        state_o.partial = CpW'(data_byte_i & Lead2Mask);
        state_o.pending = 2'd1;
      end else if (data_byte_i < Lead4Min) begin
        state_o.partial = CpW'(data_byte_i & Lead3Mask);
        state_o.pending = 2'd2;
      end else begin
        state_o.partial = CpW'(data_byte_i & Lead4Mask);
        state_o.pending = 2'd3;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/utf8_stream_decoder_core.sv =====
`default_nettype none

// UTF-8 stream decoder. Takes one byte per beat and returns one code point per
// complete character, plus a status (character, character with limit reached,
// NUL end, invalid lead byte) and the running character count of the string.
// Continuation bytes are not checked for their 10 prefix; there are no
// overlong or surrogate checks. start_string on a beat clears the string state
// before that byte is decoded. Once a string has ended, bytes give no result
// until the next start_string. Every byte is decoded in the cycle it is taken,
// by a single classify, shift and count step into the result register, so a
// byte can be taken each cycle unless out stalls; the result register refills
// as it drains. max_chars (reset 65535) must only be written while idle.
module utf8_stream_decoder_core #(
  parameter longint unsigned COUNT_MAX = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  utf8d_in_if.sink    in_i,
  utf8d_out_if.source out_o
);
  import utf8d_pkg::*;

  localparam int unsigned CNT_W = $clog2(COUNT_MAX + 1);

  logic [MaxW-1:0]  max_chars_q;
  dec_state_t       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  dec_res_t         res_d;
  logic             out_valid_q;
  logic [CpW-1:0]   code_point_q;
  status_e          status_q;
  logic [CountW-1:0] char_count_q;
  logic             in_take;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_take    = in_i.valid && in_i.ready;

  utf8d_step #(
    .COUNT_MAX (COUNT_MAX),
    .CNT_W     (CNT_W)
  ) u_step (
    .data_byte_i    (in_i.data_byte),
    .start_string_i (in_i.start_string),
    .state_i        (state_q),
    .count_i        (count_q),
    .max_chars_i    (max_chars_q),
    .state_o        (state_d),
    .count_o        (count_d),
    .res_o          (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chars_q <= '1;
      state_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_chars_q <= cfg_wdata_i;
      end
      if (in_take) begin
        state_q     <= state_d;
        count_q     <= count_d;
        out_valid_q <= res_d.valid;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && res_d.valid) begin
      code_point_q <= res_d.code_point;
      status_q     <= res_d.status;
      char_count_q <= CountW'(CmpW'(count_d));
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.code_point = code_point_q;
  assign out_o.status     = status_q;
  assign out_o.char_count = char_count_q;

`ifndef SYNTH
  a_no_pend_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q.finished && state_q.pending != 2'd0))
    else $error("sequence pending after string end");

  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && state_q.finished && !in_i.start_string) |=> state_q.finished)
    else $error("string end cleared without start");

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && state_q.finished && !in_i.start_string) |-> !res_d.valid)
    else $error("result after string end");

  a_end_zero_cp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == ST_NUL || status_q == ST_BAD)) |-> code_point_q == '0)
    else $error("non-zero code point on end status");
`endif

endmodule

`default_nettype wire

// ===== dv/utf8_stream_decoder_core_tb.sv =====
`default_nettype none

module utf8_stream_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8d_pkg::*;

  localparam int unsigned CountSat    = 65535;
  localparam int unsigned LimitCycles = 600_000;
  localparam int unsigned HoldCycles  = 250;
  localparam int unsigned RandBytes   = 300;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             start;
  } byte_beat_t;

  typedef struct packed {
    logic [CpW-1:0]    cp;
    status_e           status;
    logic [CountW-1:0] count;
  } char_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [MaxW-1:0]   cfg_wdata;

  utf8d_in_if  in_if ();
  utf8d_out_if out_if ();

  utf8_stream_decoder_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  byte_beat_t   byte_q[$];
  char_result_t expected_chars[$];

  // decoder shadow state
  logic [MaxW-1:0] char_limit   = 16'hFFFF;
  logic            str_done     = 1'b0;
  logic [1:0]      cont_left    = 2'd0;
  logic [CpW-1:0]  cp_acc       = '0;
  int unsigned     chars_seen   = 0;

  int unsigned errors       = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned bytes_sent   = 0;
  bit          src_taken    = 1'b0;
  bit          idle_on      = 1'b1;
  bit          long_hold_go = 1'b0;
  int unsigned src_gap      = 0;
  int unsigned sink_gap     = 0;
  int unsigned hold_left    = 0;
  byte_beat_t  next_beat;
  char_result_t got;
  char_result_t want;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic push_result(input logic [CpW-1:0] cp, input status_e st);
    char_result_t r;
    r.cp     = cp;
    r.status = st;
    r.count  = chars_seen[CountW-1:0];
    expected_chars.push_back(r);
  endtask

  task automatic count_char(input logic [CpW-1:0] cp);
    if (chars_seen < CountSat) chars_seen++;
    if (chars_seen >= char_limit) begin
      str_done = 1'b1;
      push_result(cp, ST_LIMIT);
    end else begin
      push_result(cp, ST_CHAR);
    end
  endtask

  task automatic decode_byte(input logic [ByteW-1:0] b, input logic st);
    if (st) begin
      str_done   = 1'b0;
      cont_left  = 2'd0;
      cp_acc     = '0;
      chars_seen = 0;
    end
    if (str_done) begin
      // ended string: beat swallowed
    end else if (cont_left != 2'd0) begin
      cp_acc    = {cp_acc[CpW-7:0], b[5:0] & ContMask[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) count_char(cp_acc);
    end else if (chars_seen >= char_limit) begin
      str_done = 1'b1;
      push_result('0, ST_LIMIT);
    end else if (b == 8'h00) begin
      str_done = 1'b1;
      push_result('0, ST_NUL);
    end else if (b < AsciiLim) begin
      count_char(CpW'(b));
    end else if (b < Lead2Min || b >= BadMin) begin
      str_done = 1'b1;
      push_result('0, ST_BAD);
    end else if (b < Lead3Min) begin
      cp_acc    = CpW'(b & Lead2Mask);
      cont_left = 2'd1;
    end else if (b < Lead4Min) begin
      cp_acc    = CpW'(b & Lead3Mask);
      cont_left = 2'd2;
    end else begin
      cp_acc    = CpW'(b & Lead4Mask);
      cont_left = 2'd3;
    end
  endtask

  // sender
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !src_taken) begin
      // beat still on offer
    end else if (src_gap != 0) begin
      src_gap--;
      in_if.valid <= 1'b0;
    end else if (byte_q.size() == 0) begin
      in_if.valid <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      src_gap = $urandom_range(0, 9);
      in_if.valid <= 1'b0;
    end else begin
      next_beat = byte_q.pop_front();
      in_if.valid        <= 1'b1;
      in_if.data_byte    <= next_beat.data;
      in_if.start_string <= next_beat.start;
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (long_hold_go) begin
        hold_left    = HoldCycles;
        long_hold_go = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap--;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 9);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got.cp     = out_if.code_point;
        got.status = status_e'(out_if.status);
        got.count  = out_if.char_count;
        if (expected_chars.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat: cp %h status %0d count %0d",
                   $time, got.cp, got.status, got.count);
        end else begin
          want = expected_chars.pop_front();
          if (got.cp !== want.cp) begin
            errors++;
            $display("%0t: code_point exp %h got %h", $time, want.cp, got.cp);
          end
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          end
          if (got.count !== want.count) begin
            errors++;
            $display("%0t: char_count exp %0d got %0d", $time, want.count, got.count);
          end
        end
      end
      if (in_if.valid && in_if.ready) decode_byte(in_if.data_byte, in_if.start_string);
      src_taken = in_if.valid && in_if.ready;
    end else begin
      src_taken = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LimitCycles) begin
      $display("utf8_stream_decoder_core_tb: errors");
      $finish;
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b, input logic st);
    byte_beat_t bb;
    bb.data  = b;
    bb.start = st;
    byte_q.push_back(bb);
    bytes_sent++;
  endtask

  task automatic drain();
    do begin
      @(negedge clk_i);
      #1;
    end while (byte_q.size() != 0 || in_if.valid || expected_chars.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_limit(input logic [MaxW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    char_limit = v;
  endtask

  function automatic logic [ByteW-1:0] cont_byte();
    if ($urandom_range(0, 15) == 0) return ByteW'($urandom_range(0, 255));
    return ByteW'($urandom_range(8'h80, 8'hBF));
  endfunction

  task automatic send_char(input logic st);
    case ($urandom_range(0, 3))
      0: send_byte(ByteW'($urandom_range(1, 8'h7F)), st);
      1: begin
        send_byte(ByteW'($urandom_range(8'hC0, 8'hDF)), st);
        send_byte(cont_byte(), 1'b0);
      end
      2: begin
        send_byte(ByteW'($urandom_range(8'hE0, 8'hEF)), st);
        repeat (2) send_byte(cont_byte(), 1'b0);
      end
      default: begin
        send_byte(ByteW'($urandom_range(8'hF0, 8'hF7)), st);
        repeat (3) send_byte(cont_byte(), 1'b0);
      end
    endcase
  endtask

  task automatic send_string(input int unsigned n_chars);
    send_char(1'b1);
    repeat (n_chars - 1) send_char(1'b0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_byte(8'h00, 1'b0);
      4: send_byte(ByteW'($urandom_range(8'h80, 8'hBF)), 1'b0);
      5: send_byte(ByteW'($urandom_range(8'hF8, 8'hFF)), 1'b0);
      6: send_byte(ByteW'($urandom_range(0, 255)), 1'b0);
      default: ;
    endcase
    // trailing junk, mostly swallowed after the end of the string
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_byte(ByteW'($urandom_range(0, 255)), 1'b0);
  endtask

  initial begin
    int unsigned phase_end;
    int unsigned phase_no;

    rst_ni                 = 1'b0;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    in_if.valid            = 1'b0;
    in_if.data_byte        = '0;
    in_if.start_string     = 1'b0;
    out_if.ready           = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: ASCII extremes, each lead class, NUL and bad leads
    send_byte(8'h41, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hC2, 1'b0); send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0);
    send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hF8, 1'b1);
    send_byte(8'hF0, 1'b1); send_byte(8'h9F, 1'b0); send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    drain();

    // zero limit ends the string at once
    set_limit(16'h0000);
    send_byte(8'h41, 1'b1);
    send_byte(8'h42, 1'b0);
    drain();
    set_limit(16'h0003);
    send_byte(8'h41, 1'b1); send_byte(8'h42, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b0);
    send_byte(8'h43, 1'b0);
    drain();

    // limit lowered to or below the count mid-string, at a lead and inside a sequence
    set_limit(16'hFFFF);
    send_byte(8'h41, 1'b1); send_byte(8'h42, 1'b0); send_byte(8'h43, 1'b0);
    drain();
    set_limit(16'h0002);
    send_byte(8'h44, 1'b0);
    drain();
    set_limit(16'hFFFF);
    send_byte(8'h41, 1'b1); send_byte(8'hC3, 1'b0);
    drain();
    set_limit(16'h0001);
    send_byte(8'hA9, 1'b0);
    drain();

    phase_no = 0;
    phase_end = bytes_sent + RandBytes;
    while (bytes_sent < phase_end) begin
      case ($urandom_range(0, 5))
        0: set_limit(16'h0000);
        1: set_limit(16'hFFFF);
        2: set_limit(16'h0001);
        3: set_limit(MaxW'($urandom_range(2, 12)));
        4: set_limit(MaxW'($urandom_range(0, 65535)));
        default: set_limit(MaxW'($urandom_range(13, 40)));
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase_no == 1) begin
        idle_on      = 1'b1;
        long_hold_go = 1'b1;
      end
      repeat (5) begin
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 6))
            send_byte(ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else
          send_string($urandom_range(1, 12));
      end
      drain();
      phase_no++;
    end

    // no idling from here on; the last string runs past a small limit
    idle_on = 1'b0;
    set_limit(MaxW'(20));
    repeat (4) send_string($urandom_range(1, 10));
    send_byte(ByteW'($urandom_range(1, 8'h7F)), 1'b1);
    repeat (24) send_byte(ByteW'($urandom_range(1, 8'h7F)), 1'b0);
    drain();

    if (errors == 0) begin
      $display("utf8_stream_decoder_core_tb: clean");
    end else begin
      $display("utf8_stream_decoder_core_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
